FILE: rtl/core/assert_macros.svh
// assertion macros used by the checker file srt_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition and consequence in the same cycle
`define SRT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// consequence in the cycle after the condition
`define SRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: rtl/core/srt_pkg.sv
// ----------------------------------------------------------------------------
// srt_pkg
// types and codes shared by the stream reservation table modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package srt_pkg;

	localparam int MAX_RESULTS = 64;
	localparam int CNT_W       = 7;

	localparam logic [2:0] K_TALKER_UPD   = 3'd0;
	localparam logic [2:0] K_TALKER_REM   = 3'd1;
	localparam logic [2:0] K_LISTENER_UPD = 3'd2;
	localparam logic [2:0] K_LISTENER_REM = 3'd3;
	localparam logic [2:0] K_FIND         = 3'd4;
	localparam logic [2:0] K_LIST         = 3'd5;
	localparam logic [2:0] K_TICK         = 3'd6;
	localparam logic [2:0] K_CLEAR        = 3'd7;

	localparam logic [3:0] ST_REGISTERED    = 4'd0;
	localparam logic [3:0] ST_UPDATED       = 4'd1;
	localparam logic [3:0] ST_REMOVED       = 4'd2;
	localparam logic [3:0] ST_NOT_FOUND     = 4'd3;
	localparam logic [3:0] ST_ZERO_SIZE     = 4'd4;
	localparam logic [3:0] ST_ZERO_INTERVAL = 4'd5;
	localparam logic [3:0] ST_NO_ADDRESS    = 4'd6;
	localparam logic [3:0] ST_WRONG_OWNER   = 4'd7;
	localparam logic [3:0] ST_NO_TALKER     = 4'd8;
	localparam logic [3:0] ST_FULL          = 4'd9;
	localparam logic [3:0] ST_EXPIRED       = 4'd10;
	localparam logic [3:0] ST_FOUND         = 4'd11;

	typedef struct packed {
		logic        valid;
		logic [11:0] vlan;
		logic [63:0] stream;
		logic [3:0]  owner;
		logic [1:0]  cls;
		logic [15:0] size;
		logic [15:0] interval;
		logic [47:0] mac;
	} talker_word_t;

	typedef struct packed {
		logic        valid;
		logic [11:0] vlan;
		logic [63:0] stream;
		logic [3:0]  port;
		logic [31:0] stamp;
	} listener_word_t;

	typedef struct packed {
		logic load;
		logic init_wr;
		logic idx_rst;
		logic t_rd;
		logic l_rd;
		logic t_clr;
		logic resp;
	} srt_cmd_t;

	typedef struct packed {
		logic [2:0] kind;
		logic       port_bad;
		logic       t_hit;
		logic       last_t;
		logic       last_l;
		logic       last_init;
		logic       cap_hit;
		logic       aging_zero;
	} srt_sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/srt_ram.sv
// ----------------------------------------------------------------------------
// srt_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: rtl/core/srt_ctrl.sv
// ----------------------------------------------------------------------------
// srt_ctrl
// sequencer: reset clearing pass, table scans and the final response
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srt_ctrl import srt_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire srt_sts_t sts,
	output srt_cmd_t      cmd,
	output logic          busy
);

	localparam logic [3:0] S_INIT  = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_DISP  = 4'd2;
	localparam logic [3:0] S_TSCAN = 4'd3;
	localparam logic [3:0] S_TWAIT = 4'd4;
	localparam logic [3:0] S_TEVAL = 4'd5;
	localparam logic [3:0] S_LSCAN = 4'd6;
	localparam logic [3:0] S_LWAIT = 4'd7;
	localparam logic [3:0] S_TCLR  = 4'd8;
	localparam logic [3:0] S_RESP  = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_INIT: begin
				cmd.init_wr = 1'b1;
				if (sts.last_init) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DISP;
				end
			end
			S_DISP: begin
				unique case (sts.kind)
					K_TALKER_UPD, K_LISTENER_UPD: state_d = sts.port_bad ? S_RESP : S_TSCAN;
					K_TALKER_REM, K_FIND:         state_d = S_TSCAN;
					K_LISTENER_REM, K_LIST:       state_d = S_LSCAN;
					K_TICK:                       state_d = sts.aging_zero ? S_IDLE : S_LSCAN;
					K_CLEAR:                      state_d = S_TCLR;
					default:                      state_d = S_RESP;
				endcase
			end
			S_TSCAN: begin
				cmd.t_rd = 1'b1;
				if (sts.last_t) state_d = S_TWAIT;
			end
			S_TWAIT: state_d = S_TEVAL;
			S_TEVAL: begin
				// a listener update goes on to the listener table only if its talker exists
				if (sts.kind == K_LISTENER_UPD && sts.t_hit) begin
					cmd.idx_rst = 1'b1;
					state_d     = S_LSCAN;
				end else begin
					state_d = S_RESP;
				end
			end
			S_LSCAN: begin
				cmd.l_rd = 1'b1;
				if (sts.last_l || sts.cap_hit) state_d = S_LWAIT;
			end
			S_LWAIT: state_d = S_RESP;
			S_TCLR: begin
				cmd.t_clr = 1'b1;
				if (sts.last_t) state_d = S_RESP;
			end
			S_RESP: begin
				cmd.resp = 1'b1;
				state_d  = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

`default_nettype wire

FILE: rtl/core/srt_datapath.sv
// ----------------------------------------------------------------------------
// srt_datapath
// request registers, talker and listener rams, scan match logic and results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srt_datapath import srt_pkg::*; #(
	parameter int TALKER_ENTRIES   = 32,
	parameter int LISTENER_ENTRIES = 64,
	parameter int PORT_COUNT       = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire srt_cmd_t    cmd,
	output srt_sts_t         sts,
	input  wire logic [2:0]  kind,
	input  wire logic [63:0] stream_id,
	input  wire logic [11:0] vlan_id,
	input  wire logic [3:0]  port,
	input  wire logic [47:0] mac_address,
	input  wire logic        address_present,
	input  wire logic [1:0]  traffic_class,
	input  wire logic [15:0] frame_size,
	input  wire logic [15:0] frame_interval,
	input  wire logic        cfg_valid,
	input  wire logic [31:0] cfg_data,
	output logic             result_valid,
	output logic [3:0]       status,
	output logic [3:0]       result_port,
	output logic [63:0]      result_stream,
	output logic [11:0]      result_vlan,
	output logic             last
);

	localparam int TAW  = (TALKER_ENTRIES > 1) ? $clog2(TALKER_ENTRIES) : 1;
	localparam int LAW  = (LISTENER_ENTRIES > 1) ? $clog2(LISTENER_ENTRIES) : 1;
	localparam int MAXD = (TALKER_ENTRIES > LISTENER_ENTRIES) ? TALKER_ENTRIES
		: LISTENER_ENTRIES;
	localparam int SW   = $clog2(MAXD + 1);

	// request
	logic [2:0]  kind_q;
	logic [63:0] stream_q;
	logic [11:0] vlan_q;
	logic [3:0]  port_q;
	logic [47:0] mac_q;
	logic        has_mac_q;
	logic [1:0]  cls_q;
	logic [15:0] size_q;
	logic [15:0] interval_q;

	logic [31:0] aging_q;
	logic [31:0] time_q;

	logic [SW-1:0] idx_q;
	logic          rdt_s1;
	logic          rdl_s1;
	logic [SW-1:0] ridx_s1;

	logic             t_hit_q, t_free_q;
	logic [TAW-1:0]   t_idx_q, t_free_idx_q;
	talker_word_t     t_word_q;
	logic             l_hit_q, l_free_q;
	logic [LAW-1:0]   l_idx_q, l_free_idx_q;
	logic [CNT_W-1:0] cnt_q;
	logic             hold_v_q;
	logic [3:0]       hold_port_q;
	logic [63:0]      hold_stream_q;
	logic [11:0]      hold_vlan_q;

	// ram ports
	logic           t_we, l_we;
	logic [TAW-1:0] t_waddr;
	logic [LAW-1:0] l_waddr;
	talker_word_t   t_wdata, t_rword;
	listener_word_t l_wdata, l_rword;

	// result word
	logic        emit_v, emit_last;
	logic [3:0]  emit_status, emit_port;
	logic [63:0] emit_stream;
	logic [11:0] emit_vlan;

	logic        port_bad;
	logic        t_match, t_free_seen;
	logic        l_key, l_match, l_free_seen;
	logic        cap_ok, l_take;
	logic [31:0] age;

	srt_ram #(.WIDTH($bits(talker_word_t)), .DEPTH(TALKER_ENTRIES)) u_talker_ram (
		.clk   (clk),
		.we    (t_we),
		.waddr (t_waddr),
		.wdata (t_wdata),
		.raddr (idx_q[TAW-1:0]),
		.rdata (t_rword)
	);

	srt_ram #(.WIDTH($bits(listener_word_t)), .DEPTH(LISTENER_ENTRIES)) u_listener_ram (
		.clk   (clk),
		.we    (l_we),
		.waddr (l_waddr),
		.wdata (l_wdata),
		.raddr (idx_q[LAW-1:0]),
		.rdata (l_rword)
	);

	assign port_bad    = (32'(port_q) >= 32'(PORT_COUNT));
	assign t_match     = rdt_s1 && t_rword.valid && t_rword.vlan == vlan_q
		&& t_rword.stream == stream_q;
	assign t_free_seen = rdt_s1 && !t_rword.valid;
	assign l_key       = l_rword.valid && l_rword.vlan == vlan_q && l_rword.stream == stream_q;
	assign l_match     = rdl_s1 && l_key && l_rword.port == port_q;
	assign l_free_seen = rdl_s1 && !l_rword.valid;
	assign cap_ok      = (cnt_q < CNT_W'(MAX_RESULTS));
	assign age         = time_q - l_rword.stamp;
	// a listed listener or a due expiry becomes the held result
	assign l_take      = rdl_s1 && cap_ok && (
		(kind_q == K_LIST && l_key) ||
		(kind_q == K_TICK && l_rword.valid && age >= aging_q));

	always_comb begin
		t_we        = 1'b0;
		t_waddr     = idx_q[TAW-1:0];
		t_wdata     = '0;
		l_we        = 1'b0;
		l_waddr     = idx_q[LAW-1:0];
		l_wdata     = '0;
		emit_v      = 1'b0;
		emit_status = ST_REGISTERED;
		emit_port   = port_q;
		emit_stream = stream_q;
		emit_vlan   = vlan_q;
		emit_last   = 1'b1;

		if (cmd.init_wr) begin
			t_we = (idx_q < SW'(TALKER_ENTRIES));
			l_we = (idx_q < SW'(LISTENER_ENTRIES));
		end
		if (cmd.t_clr) begin
			t_we = 1'b1;
		end

		if (l_take) begin
			if (kind_q == K_TICK) begin
				l_we          = 1'b1;
				l_waddr       = ridx_s1[LAW-1:0];
				l_wdata       = l_rword;
				l_wdata.valid = 1'b0;
			end
			// the previous held word is now known not to be the final one
			if (hold_v_q) begin
				emit_v      = 1'b1;
				emit_status = (kind_q == K_TICK) ? ST_EXPIRED : ST_FOUND;
				emit_port   = hold_port_q;
				emit_stream = hold_stream_q;
				emit_vlan   = hold_vlan_q;
				emit_last   = 1'b0;
			end
		end

		if (cmd.resp) begin
			emit_v = 1'b1;
			unique case (kind_q)
				K_TALKER_UPD: begin
					if (port_bad) begin
						emit_status = ST_NOT_FOUND;
					end else if (t_hit_q) begin
						if (t_word_q.owner != port_q) begin
							emit_status = ST_WRONG_OWNER;
							emit_port   = t_word_q.owner;
						end else begin
							t_we    = 1'b1;
							t_waddr = t_idx_q;
							t_wdata = t_word_q;
							t_wdata.cls = cls_q;
							if (size_q != 16'd0) t_wdata.size = size_q;
							if (interval_q != 16'd0) t_wdata.interval = interval_q;
							if (has_mac_q) t_wdata.mac = mac_q;
							emit_status = ST_UPDATED;
						end
					end else if (size_q == 16'd0) begin
						emit_status = ST_ZERO_SIZE;
					end else if (interval_q == 16'd0) begin
						emit_status = ST_ZERO_INTERVAL;
					end else if (!has_mac_q) begin
						emit_status = ST_NO_ADDRESS;
					end else if (!t_free_q) begin
						emit_status = ST_FULL;
					end else begin
						t_we             = 1'b1;
						t_waddr          = t_free_idx_q;
						t_wdata.valid    = 1'b1;
						t_wdata.vlan     = vlan_q;
						t_wdata.stream   = stream_q;
						t_wdata.owner    = port_q;
						t_wdata.cls      = cls_q;
						t_wdata.size     = size_q;
						t_wdata.interval = interval_q;
						t_wdata.mac      = mac_q;
						emit_status      = ST_REGISTERED;
					end
				end
				K_TALKER_REM: begin
					if (!t_hit_q) begin
						emit_status = ST_NOT_FOUND;
					end else if (t_word_q.owner != port_q) begin
						emit_status = ST_WRONG_OWNER;
						emit_port   = t_word_q.owner;
					end else begin
						t_we          = 1'b1;
						t_waddr       = t_idx_q;
						t_wdata       = t_word_q;
						t_wdata.valid = 1'b0;
						emit_status   = ST_REMOVED;
					end
				end
				K_LISTENER_UPD: begin
					l_wdata.valid  = 1'b1;
					l_wdata.vlan   = vlan_q;
					l_wdata.stream = stream_q;
					l_wdata.port   = port_q;
					l_wdata.stamp  = time_q;
					if (port_bad) begin
						emit_status = ST_NOT_FOUND;
					end else if (!t_hit_q) begin
						emit_status = ST_NO_TALKER;
					end else if (l_hit_q) begin
						l_we        = 1'b1;
						l_waddr     = l_idx_q;
						emit_status = ST_UPDATED;
					end else if (!l_free_q) begin
						emit_status = ST_FULL;
					end else begin
						l_we        = 1'b1;
						l_waddr     = l_free_idx_q;
						emit_status = ST_REGISTERED;
					end
				end
				K_LISTENER_REM: begin
					if (!l_hit_q) begin
						emit_status = ST_NOT_FOUND;
					end else begin
						l_we        = 1'b1;
						l_waddr     = l_idx_q;
						emit_status = ST_REMOVED;
					end
				end
				K_FIND: begin
					if (!t_hit_q) begin
						emit_status = ST_NOT_FOUND;
					end else begin
						emit_status = ST_FOUND;
						emit_port   = t_word_q.owner;
					end
				end
				K_LIST, K_TICK: begin
					if (hold_v_q) begin
						emit_status = (kind_q == K_TICK) ? ST_EXPIRED : ST_FOUND;
						emit_port   = hold_port_q;
						emit_stream = hold_stream_q;
						emit_vlan   = hold_vlan_q;
					end else if (kind_q == K_LIST) begin
						emit_status = ST_NOT_FOUND;
					end else begin
						emit_v = 1'b0;
					end
				end
				K_CLEAR: begin
					emit_status = ST_REMOVED;
					emit_port   = 4'd0;
				end
				default: emit_v = 1'b0;
			endcase
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aging_q      <= '0;
			time_q       <= '0;
			idx_q        <= '0;
			rdt_s1       <= 1'b0;
			rdl_s1       <= 1'b0;
			t_hit_q      <= 1'b0;
			t_free_q     <= 1'b0;
			l_hit_q      <= 1'b0;
			l_free_q     <= 1'b0;
			cnt_q        <= '0;
			hold_v_q     <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (cfg_valid) aging_q <= cfg_data;
			rdt_s1       <= cmd.t_rd;
			rdl_s1       <= cmd.l_rd;
			result_valid <= emit_v;
			if (cmd.load) begin
				idx_q    <= '0;
				t_hit_q  <= 1'b0;
				t_free_q <= 1'b0;
				l_hit_q  <= 1'b0;
				l_free_q <= 1'b0;
				cnt_q    <= '0;
				hold_v_q <= 1'b0;
				if (kind == K_TICK) time_q <= time_q + 32'd1;
			end else begin
				if (cmd.idx_rst) begin
					idx_q <= '0;
				end else if (cmd.init_wr || cmd.t_rd || cmd.l_rd || cmd.t_clr) begin
					idx_q <= idx_q + SW'(1);
				end
				if (t_match) t_hit_q <= 1'b1;
				if (t_free_seen) t_free_q <= 1'b1;
				if (l_match) l_hit_q <= 1'b1;
				if (l_free_seen) l_free_q <= 1'b1;
				if (l_take) begin
					cnt_q    <= cnt_q + CNT_W'(1);
					hold_v_q <= 1'b1;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		ridx_s1 <= idx_q;
		if (cmd.load) begin
			kind_q     <= kind;
			stream_q   <= stream_id;
			vlan_q     <= vlan_id;
			port_q     <= port;
			mac_q      <= mac_address;
			has_mac_q  <= address_present;
			cls_q      <= traffic_class;
			size_q     <= frame_size;
			interval_q <= frame_interval;
		end
		if (t_match && !t_hit_q) begin
			t_idx_q  <= ridx_s1[TAW-1:0];
			t_word_q <= t_rword;
		end
		if (t_free_seen && !t_free_q) t_free_idx_q <= ridx_s1[TAW-1:0];
		if (l_match && !l_hit_q) l_idx_q <= ridx_s1[LAW-1:0];
		if (l_free_seen && !l_free_q) l_free_idx_q <= ridx_s1[LAW-1:0];
		if (l_take) begin
			hold_port_q   <= l_rword.port;
			hold_stream_q <= l_rword.stream;
			hold_vlan_q   <= l_rword.vlan;
		end
		if (emit_v) begin
			status        <= emit_status;
			result_port   <= emit_port;
			result_stream <= emit_stream;
			result_vlan   <= emit_vlan;
			last          <= emit_last;
		end
	end

	always_comb begin
		sts            = '0;
		sts.kind       = kind_q;
		sts.port_bad   = port_bad;
		sts.t_hit      = t_hit_q;
		sts.last_t     = (idx_q == SW'(TALKER_ENTRIES - 1));
		sts.last_l     = (idx_q == SW'(LISTENER_ENTRIES - 1));
		sts.last_init  = (idx_q == SW'(MAXD - 1));
		sts.cap_hit    = (cnt_q == CNT_W'(MAX_RESULTS));
		sts.aging_zero = (aging_q == 32'd0);
	end

endmodule

`default_nettype wire

FILE: rtl/core/stream_reservation_table.sv
// ----------------------------------------------------------------------------
// stream_reservation_table
// talker / listener reservation registry with listener aging
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Results come out one
// per cycle on status, result_port, result_stream, result_vlan with
// result_valid high for exactly one cycle; last marks the final word of an
// item. The receiver cannot stall the block.
// Each scan walks a table in ram, one entry per cycle; a new item is taken
// only once the previous one is done and busy is low. What each kind does:
//   talker requests and find: talker table scan, then the response
//   listener update: talker table scan, listener table scan, response; the
//   listener scan is skipped when the talker is missing
//   talker or listener update from a port out of range: response only
//   listener remove, list, tick: listener table scan (ends early once 64
//   results are found); tick with aging disabled: no scan, no result
//   clear talkers: every talker entry is cleared, then the response
// The single-entry-per-cycle ram read port sets the length of each scan.
// After reset busy stays high while both tables are cleared; aging_time
// resets to 0. aging_time is written through cfg_valid/cfg_data (cfg_ready
// is always high); the user must do so only while the block is idle, as the
// block itself does not enforce it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stream_reservation_table import srt_pkg::*; #(
	parameter int TALKER_ENTRIES   = 32,
	parameter int LISTENER_ENTRIES = 64,
	parameter int PORT_COUNT       = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  kind,
	input  wire logic [63:0] stream_id,
	input  wire logic [11:0] vlan_id,
	input  wire logic [3:0]  port,
	input  wire logic [47:0] mac_address,
	input  wire logic        address_present,
	input  wire logic [1:0]  traffic_class,
	input  wire logic [15:0] frame_size,
	input  wire logic [15:0] frame_interval,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] cfg_data,
	output logic             result_valid,
	output logic [3:0]       status,
	output logic [3:0]       result_port,
	output logic [63:0]      result_stream,
	output logic [11:0]      result_vlan,
	output logic             last
);

	srt_cmd_t cmd;
	srt_sts_t sts;

	assign cfg_ready = 1'b1;

	srt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	srt_datapath #(
		.TALKER_ENTRIES   (TALKER_ENTRIES),
		.LISTENER_ENTRIES (LISTENER_ENTRIES),
		.PORT_COUNT       (PORT_COUNT)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.kind            (kind),
		.stream_id       (stream_id),
		.vlan_id         (vlan_id),
		.port            (port),
		.mac_address     (mac_address),
		.address_present (address_present),
		.traffic_class   (traffic_class),
		.frame_size      (frame_size),
		.frame_interval  (frame_interval),
		.cfg_valid       (cfg_valid),
		.cfg_data        (cfg_data),
		.result_valid    (result_valid),
		.status          (status),
		.result_port     (result_port),
		.result_stream   (result_stream),
		.result_vlan     (result_vlan),
		.last            (last)
	);

endmodule

`default_nettype wire

FILE: rtl/core/srt_checker.sv
// ----------------------------------------------------------------------------
// srt_checker
// port level checks on item acceptance and result sequencing
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module srt_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic result_valid,
	input wire logic last
);

	// an accepted item makes the block busy in the cycle after it is taken
	`SRT_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)

	// a word that is not the final one only shows while the item is still running
	`SRT_ASSERT_SAME(a_mid_busy, clk, arst_n, result_valid && !last, busy)

	// the final word of an item is never followed directly by another word
	`SRT_ASSERT_NEXT(a_last_gap, clk, arst_n, result_valid && last, !result_valid)

endmodule

bind stream_reservation_table srt_checker u_srt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid),
	.last         (last)
);

`default_nettype wire
